>>> sv/amst_pkg.sv
`default_nettype none
// ============================================================================
// amst_pkg
// Shared types, constants and the sine table of the AM sine tone synthesiser.
// ============================================================================
package amst_pkg;

    // Phase accumulators and sine table
    localparam int PHASE_BITS   = 32;
    localparam int SINE_ENTRIES = 256;
    localparam int ADDR_BITS    = $clog2(SINE_ENTRIES);
    localparam int SAMPLE_BITS  = 16;
    localparam int SINE_PEAK    = 32767;

    // Fade gain
    localparam int FADE_STEPS = 1323;
    localparam int FADE_BITS  = 11;

    // Frequencies in 1/16 Hz
    localparam int AM_LIMIT   = 480;
    localparam int DIRECT_MAX = 16000;
    localparam int CARRIER_F  = 3200;
    localparam int RATE_X16   = 705600;
    localparam int F_BITS     = 14;

    // Volume and peak level
    localparam int VOL_BITS   = 7;
    localparam int VOL_MAX    = 100;
    localparam int VOL_RESET  = 60;
    localparam int TONE_PEAK  = 12000;

    // Configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_TONE_ENABLE = 2'd0,
        REG_TARGET_FREQ = 2'd1,
        REG_VOLUME      = 2'd2
    } cfg_reg_t;

    // Stream payloads
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 24;

    typedef enum logic {
        CMD_TONE   = 1'b0,
        CMD_SOURCE = 1'b1
    } cmd_t;

    // Phase increment divider: (f << PHASE_BITS + RATE_X16/2) / RATE_X16, one bit a cycle
    localparam int INC_DIVIDEND_BITS = F_BITS + PHASE_BITS;
    localparam int INC_REM_BITS      = 20;
    localparam int INC_STEPS         = INC_DIVIDEND_BITS;
    localparam int INC_STEP_BITS     = $clog2(INC_STEPS);
    localparam logic [INC_REM_BITS-1:0] RATE_DIVISOR = INC_REM_BITS'(RATE_X16);
    localparam logic [INC_DIVIDEND_BITS-1:0] RATE_HALF = INC_DIVIDEND_BITS'(RATE_X16 / 2);

    localparam longint unsigned CARRIER_INC_L =
        ((longint'(CARRIER_F) << PHASE_BITS) + longint'(RATE_X16 / 2)) / RATE_X16;
    localparam logic [PHASE_BITS-1:0] CARRIER_INC = PHASE_BITS'(CARRIER_INC_L);

    // Serial multiply then divide unit
    localparam int OPA_BITS     = 16;
    localparam int OPB1_BITS    = 16;
    localparam int OPB2_BITS    = 21;
    localparam int PROD_BITS    = 52;
    localparam int DIVISOR_BITS = 38;
    localparam int QUO_BITS     = 16;
    localparam int MUL1_STEPS   = OPB1_BITS;
    localparam int MUL2_STEPS   = OPB2_BITS;
    localparam int DIV_STEPS    = QUO_BITS;
    localparam int STEP_BITS    = $clog2(MUL2_STEPS);

    localparam longint unsigned DIV_TONE_L   = longint'(SINE_PEAK) * longint'(VOL_MAX);
    localparam longint unsigned DIV_AM_L     =
        longint'(SINE_PEAK) * longint'(2 * SINE_PEAK) * longint'(VOL_MAX);
    localparam longint unsigned DIV_SOURCE_L = longint'(VOL_MAX) * longint'(FADE_STEPS);
    localparam logic [DIVISOR_BITS-1:0] DIV_TONE   = DIVISOR_BITS'(DIV_TONE_L);
    localparam logic [DIVISOR_BITS-1:0] DIV_AM     = DIVISOR_BITS'(DIV_AM_L);
    localparam logic [DIVISOR_BITS-1:0] DIV_SOURCE = DIVISOR_BITS'(DIV_SOURCE_L);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL1,
        MD_MUL2,
        MD_DIV
    } md_phase_t;

    typedef struct packed {
        logic                    start;
        logic [OPA_BITS-1:0]     a;
        logic [OPB1_BITS-1:0]    b1;
        logic [OPB2_BITS-1:0]    b2;
        logic [DIVISOR_BITS-1:0] divisor;
    } md_req_t;

    // Top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC
    } state_t;

    // Sine table, built at elaboration from an odd Taylor series in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef logic signed [SAMPLE_BITS-1:0] sine_rom_t [SINE_ENTRIES];

    function automatic int quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum_pos;
        longint unsigned sum_neg;
        longint unsigned v;
        x       = (r * HALF_PI_Q30) / SINE_ENTRIES;
        term    = x;
        sum_pos = x;
        sum_neg = 64'd0;
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
                sum_neg = sum_neg + term;
            else
                sum_pos = sum_pos + term;
        end
        v = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
        v = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return int'(v);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        int        quad;
        int        rem_q;
        int        v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            quad  = (4 * i) / SINE_ENTRIES;
            rem_q = (4 * i) % SINE_ENTRIES;
            if ((quad % 2) == 1)
                v = quarter_sine(longint'(SINE_ENTRIES - rem_q));
            else
                v = quarter_sine(longint'(rem_q));
            rom[i] = ((quad / 2) % 2 == 1) ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

>>> sv/am_sine_tone_synth_with_fade.sv
`default_nettype none
// ============================================================================
// am_sine_tone_synth_with_fade
// Sine tone synthesiser with slow amplitude modulation and a faded
// source-sample path, producing offset-binary DAC codes.
// ============================================================================
// Usage:
//   One input transaction per 44.1 kHz sample slot. tuser selects a tone
//   tick or a source sample; tdata carries the sample and the fade direction.
//   A tone tick gives one output transaction when the tone is enabled and the
//   target frequency is non-zero, otherwise none. A source sample always gives
//   one output transaction.
//   A new item is accepted only once the result of the item before has been
//   loaded into the output register. The serial arithmetic unit does the
//   work: two shift-add multiplication passes, then a restoring division.
//   A suppressed tone tick is accepted and leaves the sequencer idle.
//   Writing target_freq starts a serial division for the phase increment;
//   tready stays low until it completes.
//   Reset clears the phases and the fade gain, disables the tone, sets the
//   target to zero and the volume to 60 percent.
//   When the receiver stalls, the result waits in the output register while
//   the next item may already be accepted and worked on; that item then
//   waits in the arithmetic unit until the output register is free.
// ============================================================================
module am_sine_tone_synth_with_fade (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [amst_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [amst_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [amst_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // [15:0] source_sample, [16] fade_up
    input  logic                                 s_axis_tuser,  // [0] command
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [amst_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata   // [15:0] dac_code, [16] fade_finished
);
    import amst_pkg::*;

    // Configuration
    logic                    tone_enable_reg;
    logic [CFG_DATA_BITS-1:0] target_freq_reg;
    logic [VOL_BITS-1:0]     volume_reg;

    // Synthesis state
    logic [PHASE_BITS-1:0]   carrier_phase_reg;
    logic [PHASE_BITS-1:0]   envelope_phase_reg;
    logic [FADE_BITS-1:0]    fade_level_reg, fade_level_next;

    // Item in progress
    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic signed [SAMPLE_BITS-1:0] source_reg;
    logic                    finished_reg, finished_next;
    logic                    neg_reg, neg_next;

    // Output register
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_dac_reg;
    logic                    out_fin_reg;

    // Control strobes and datapath signals
    logic                    in_accept;
    logic                    is_source;
    logic                    fade_up;
    logic                    tone_live;
    logic                    am_mode;
    logic                    phase_step;
    logic                    out_load;
    logic                    out_free;
    logic                    inc_busy;
    logic                    inc_start;
    logic [PHASE_BITS-1:0]   tone_inc;
    logic                    md_busy;
    logic [QUO_BITS-1:0]     md_quo;
    md_req_t                 md_req;
    md_req_t                 load_req;
    logic [VOL_BITS-1:0]     vol_clamped;
    logic [OPB2_BITS-1:0]    tone_gain;
    logic [OPB2_BITS-1:0]    fade_gain;
    logic signed [SAMPLE_BITS-1:0] carrier_s;
    logic signed [SAMPLE_BITS-1:0] envelope_s;
    logic [SAMPLE_BITS:0]    envelope_sum;
    logic [SAMPLE_BITS-1:0]  dac_value;

    assign is_source = (s_axis_tuser == CMD_SOURCE);
    assign fade_up   = s_axis_tdata[SAMPLE_BITS];
    assign tone_live = tone_enable_reg && (target_freq_reg != '0);
    assign am_mode   = (target_freq_reg <= CFG_DATA_BITS'(AM_LIMIT));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign inc_start = cfg_we && (cfg_addr == REG_TARGET_FREQ);

    // Phase increment for the target frequency
    amst_phase_inc u_phase_inc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (inc_start),
        .freq  (cfg_wdata),
        .busy  (inc_busy),
        .inc   (tone_inc)
    );

    // Serial multiply and divide
    amst_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .busy  (md_busy),
        .quo   (md_quo)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_enable_reg <= 1'b0;
            target_freq_reg <= '0;
            volume_reg      <= VOL_BITS'(VOL_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_TONE_ENABLE: tone_enable_reg <= cfg_wdata[0];
                REG_TARGET_FREQ: target_freq_reg <= cfg_wdata;
                REG_VOLUME:      volume_reg      <= cfg_wdata[VOL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Step the fade gain one level toward its end
    always_comb
    begin
        fade_level_next = fade_level_reg;
        if (fade_up)
        begin
            if (fade_level_reg < FADE_BITS'(FADE_STEPS))
                fade_level_next = fade_level_reg + 1'b1;
            else
                fade_level_next = FADE_BITS'(FADE_STEPS);
        end
        else if (fade_level_reg != '0)
        begin
            fade_level_next = fade_level_reg - 1'b1;
        end
        finished_next = is_source && !fade_up && (fade_level_next == '0);
    end

    // Build the operands for the arithmetic unit
    always_comb
    begin
        vol_clamped  = (volume_reg > VOL_BITS'(VOL_MAX)) ? VOL_BITS'(VOL_MAX) : volume_reg;
        tone_gain    = OPB2_BITS'(vol_clamped) * OPB2_BITS'(TONE_PEAK);
        fade_gain    = OPB2_BITS'(vol_clamped) * OPB2_BITS'(fade_level_reg);
        carrier_s    = SINE_ROM[carrier_phase_reg[PHASE_BITS-1 -: ADDR_BITS]];
        envelope_s   = SINE_ROM[envelope_phase_reg[PHASE_BITS-1 -: ADDR_BITS]];
        envelope_sum = (SAMPLE_BITS+1)'(SINE_PEAK) + {envelope_s[SAMPLE_BITS-1], envelope_s};
        load_req.start = 1'b1;
        if (cmd_reg == CMD_SOURCE)
        begin
            neg_next         = source_reg[SAMPLE_BITS-1];
            load_req.a       = neg_next ? OPA_BITS'(-source_reg) : OPA_BITS'(source_reg);
            load_req.b1      = OPB1_BITS'(1);
            load_req.b2      = fade_gain;
            load_req.divisor = DIV_SOURCE;
        end
        else
        begin
            neg_next    = carrier_s[SAMPLE_BITS-1];
            load_req.a  = neg_next ? OPA_BITS'(-carrier_s) : OPA_BITS'(carrier_s);
            load_req.b2 = tone_gain;
            if (am_mode)
            begin
                load_req.b1      = envelope_sum[OPB1_BITS-1:0];
                load_req.divisor = DIV_AM;
            end
            else
            begin
                load_req.b1      = OPB1_BITS'(1);
                load_req.divisor = DIV_TONE;
            end
        end
    end

    // Sequence one item: accept, load operands, wait for the result
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        md_req        = '0;
        phase_step    = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = !inc_busy;
                if (s_axis_tvalid && !inc_busy && (is_source || tone_live))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                md_req     = load_req;
                phase_step = (cmd_reg == CMD_TONE);
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!md_busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance the phases after the table reads; fade on source transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg  <= '0;
            envelope_phase_reg <= '0;
            fade_level_reg     <= '0;
        end
        else
        begin
            if (phase_step)
            begin
                if (am_mode)
                begin
                    carrier_phase_reg  <= carrier_phase_reg + CARRIER_INC;
                    envelope_phase_reg <= envelope_phase_reg + tone_inc;
                end
                else
                begin
                    carrier_phase_reg <= carrier_phase_reg + tone_inc;
                end
            end
            if (in_accept && is_source)
                fade_level_reg <= fade_level_next;
        end
    end

    // Capture the item and its sign
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd_t'(s_axis_tuser);
            source_reg   <= s_axis_tdata[SAMPLE_BITS-1:0];
            finished_reg <= finished_next;
        end
        if (phase_step || (state_reg == ST_LOAD))
            neg_reg <= neg_next;
    end

    // Apply the sign, saturate and offset to a DAC code
    always_comb
    begin
        if (neg_reg)
        begin
            if (md_quo > QUO_BITS'(SINE_PEAK + 1))
                dac_value = '0;
            else
                dac_value = SAMPLE_BITS'((SAMPLE_BITS+1)'(SINE_PEAK + 1) - {1'b0, md_quo});
        end
        else
        begin
            if (md_quo > QUO_BITS'(SINE_PEAK))
                dac_value = {SAMPLE_BITS{1'b1}};
            else
                dac_value = {1'b1, md_quo[SAMPLE_BITS-2:0]};
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_dac_reg <= dac_value;
            out_fin_reg <= finished_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_BITS-SAMPLE_BITS-1)'(0), out_fin_reg, out_dac_reg};

endmodule
`default_nettype wire

>>> sv/amst_phase_inc.sv
`default_nettype none
// ============================================================================
// amst_phase_inc
// Bit-serial restoring divider that turns a target frequency into a phase
// increment, one quotient bit per cycle.
// ============================================================================
module amst_phase_inc (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [amst_pkg::CFG_DATA_BITS-1:0] freq,
    output logic                            busy,
    output logic [amst_pkg::PHASE_BITS-1:0] inc
);
    import amst_pkg::*;

    logic                         busy_reg, busy_next;
    logic [INC_STEP_BITS-1:0]     step_reg, step_next;
    logic [INC_DIVIDEND_BITS-1:0] shift_reg, shift_next;
    logic [INC_REM_BITS-1:0]      rem_reg, rem_next;
    logic [PHASE_BITS-1:0]        inc_reg, inc_next;
    logic [F_BITS-1:0]            freq_clamped;
    logic [INC_REM_BITS:0]        rem_shift;
    logic [INC_REM_BITS:0]        rem_diff;
    logic                         q_bit;

    // Clamp to the highest direct tone
    assign freq_clamped = (freq > CFG_DATA_BITS'(DIRECT_MAX)) ? F_BITS'(DIRECT_MAX)
                                                              : freq[F_BITS-1:0];

    // Trial subtract of the divisor from the shifted remainder
    assign rem_shift = {rem_reg, shift_reg[INC_DIVIDEND_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, RATE_DIVISOR};
    assign q_bit     = !rem_diff[INC_REM_BITS];

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        inc_next   = inc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = INC_STEP_BITS'(INC_STEPS - 1);
            shift_next = {freq_clamped, PHASE_BITS'(0)} + RATE_HALF;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = q_bit ? rem_diff[INC_REM_BITS-1:0] : rem_shift[INC_REM_BITS-1:0];
            shift_next = {shift_reg[INC_DIVIDEND_BITS-2:0], q_bit};
            step_next  = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                inc_next  = shift_next[PHASE_BITS-1:0];
            end
        end
    end

    // Hold control and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            inc_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            inc_reg  <= inc_next;
        end
    end

    // Advance the dividend and remainder shift registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign busy = busy_reg;
    assign inc  = inc_reg;

endmodule
`default_nettype wire

>>> sv/amst_muldiv.sv
`default_nettype none
// ============================================================================
// amst_muldiv
// Shared serial arithmetic unit: two shift-add multiply passes, one
// multiplier bit per cycle, then a restoring divide, one quotient bit per
// cycle. Computes (a * b1 * b2) / divisor, truncated.
// ============================================================================
module amst_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amst_pkg::md_req_t             req,
    output logic                          busy,
    output logic [amst_pkg::QUO_BITS-1:0] quo
);
    import amst_pkg::*;

    md_phase_t               phase_reg, phase_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic [PROD_BITS-1:0]    mcand_reg, mcand_next;
    logic [PROD_BITS-1:0]    acc_reg, acc_next;
    logic [PROD_BITS-1:0]    acc_sum;
    logic [OPB2_BITS-1:0]    mplier_reg, mplier_next;
    logic [OPB2_BITS-1:0]    b2_reg, b2_next;
    logic [DIVISOR_BITS-1:0] divisor_reg, divisor_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [QUO_BITS-1:0]     quo_reg, quo_next;
    logic [DIVISOR_BITS:0]   rem_shift;
    logic [DIVISOR_BITS:0]   rem_diff;
    logic                    q_bit;

    // Add the shifted multiplicand where the multiplier bit is set
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // Trial subtract; numerator bits leave the top of the quotient register
    assign rem_shift = {rem_reg, quo_reg[QUO_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = !rem_diff[DIVISOR_BITS];

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        mplier_next  = mplier_reg;
        b2_next      = b2_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        case (phase_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next   = PROD_BITS'(req.a);
                    mplier_next  = OPB2_BITS'(req.b1);
                    acc_next     = '0;
                    b2_next      = req.b2;
                    divisor_next = req.divisor;
                    step_next    = STEP_BITS'(MUL1_STEPS - 1);
                    phase_next   = MD_MUL1;
                end
            end
            MD_MUL1:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[PROD_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[OPB2_BITS-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    mcand_next  = acc_sum;
                    acc_next    = '0;
                    mplier_next = b2_reg;
                    step_next   = STEP_BITS'(MUL2_STEPS - 1);
                    phase_next  = MD_MUL2;
                end
            end
            MD_MUL2:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[PROD_BITS-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[OPB2_BITS-1:1]};
                step_next   = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    rem_next   = DIVISOR_BITS'(acc_sum >> QUO_BITS);
                    quo_next   = acc_sum[QUO_BITS-1:0];
                    step_next  = STEP_BITS'(DIV_STEPS - 1);
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next  = q_bit ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
                quo_next  = {quo_reg[QUO_BITS-2:0], q_bit};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    phase_next = MD_IDLE;
            end
            default:
            begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    // Hold the sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    // Advance the operand, product and quotient shift registers
    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        acc_reg     <= acc_next;
        mplier_reg  <= mplier_next;
        b2_reg      <= b2_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign busy = (phase_reg != MD_IDLE);
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> sim/amst_tone_checker.sv
// ----------------------------------------------------------------------------
// amst_tone_checker
// Watches the configuration port and both stream channels of the AM sine
// tone synthesiser, predicts every DAC code and compares it on arrival.
// ----------------------------------------------------------------------------
module amst_tone_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [amst_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [amst_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [amst_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [15:0] source_sample, [16] fade_up
    input  logic                                s_axis_tuser,  // [0] command
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [amst_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,  // [15:0] dac_code, [16] fade_finished
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tone generator figures, frequencies in 1/16 Hz
    localparam int              TAB_SIZE         = 256;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int              GAIN_STEPS       = 1323;
    localparam int unsigned     AM_CEILING       = 480;
    localparam int unsigned     DIRECT_CEILING   = 16000;
    localparam int unsigned     CARRIER_X16      = 3200;
    localparam longint unsigned SLOT_RATE_X16    = 64'd705600;
    localparam longint          TONE_DIV         = 64'sd3276700;
    localparam longint          AM_DIV           = 64'sd214735257800;
    localparam longint          FADE_DIV         = 64'sd132300;

    typedef struct packed {
        logic [15:0] code;
        logic        done;
    } dac_result_t;

    int          sine_tab [TAB_SIZE];
    dac_result_t dac_queue [$];

    // Predictor state and register copies
    logic        tone_on;
    logic [15:0] freq_x16;
    logic [6:0]  vol_pct;
    logic [31:0] carrier_acc;
    logic [31:0] envelope_acc;
    int          gain_step;
    int          fail_tally;

    // One quarter of the sine wave from an odd power series in Q30
    function automatic int quarter_wave(input int r);
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos_sum;
        longint unsigned neg_sum;
        longint unsigned mag;
        x       = (longint'(r) * QUARTER_TURN_Q30) / TAB_SIZE;
        term    = x;
        pos_sum = x;
        neg_sum = 64'd0;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                neg_sum += term;
            else
                pos_sum += term;
        end
        mag = (pos_sum > neg_sum) ? pos_sum - neg_sum : 64'd0;
        mag = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return int'(mag);
    endfunction

    // Phase step for a frequency in 1/16 Hz, rounded to nearest
    function automatic logic [31:0] phase_step(input int unsigned f16);
        longint unsigned num;
        num = (longint'(f16) << 32) + SLOT_RATE_X16 / 2;
        return 32'(num / SLOT_RATE_X16);
    endfunction

    // Work out the DAC code of one input transaction; 0 when none comes out
    function automatic bit predict_dac(input amst_pkg::cmd_t cmd,
                                       input logic signed [15:0] pcm,
                                       input logic up,
                                       output dac_result_t res);
        longint      vol;
        longint      carrier;
        longint      env;
        longint      level;
        int unsigned f_eff;
        vol      = (vol_pct > 7'd100) ? 64'sd100 : longint'(vol_pct);
        res.done = 1'b0;
        if (cmd == amst_pkg::CMD_SOURCE)
        begin
            // Step the fade gain, then scale the source sample
            if (up)
            begin
                if (gain_step < GAIN_STEPS)
                    gain_step++;
            end
            else if (gain_step > 0)
                gain_step--;
            level    = (longint'(pcm) * vol * longint'(gain_step)) / FADE_DIV;
            res.done = !up && gain_step == 0;
        end
        else
        begin
            if (!tone_on || freq_x16 == 16'd0)
                return 1'b0;
            carrier = sine_tab[carrier_acc[31:24]];
            if (freq_x16 <= AM_CEILING)
            begin
                // Slow target: modulate the fixed carrier by the envelope
                env          = 32767 + sine_tab[envelope_acc[31:24]];
                level        = (carrier * env * 12000 * vol) / AM_DIV;
                carrier_acc  = carrier_acc + phase_step(CARRIER_X16);
                envelope_acc = envelope_acc + phase_step(freq_x16);
            end
            else
            begin
                f_eff       = (freq_x16 > DIRECT_CEILING) ? DIRECT_CEILING : freq_x16;
                level       = (carrier * 12000 * vol) / TONE_DIV;
                carrier_acc = carrier_acc + phase_step(f_eff);
            end
        end
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        res.code = 16'(level + 32768);
        return 1'b1;
    endfunction

    // Build the sine table
    initial
    begin
        int quad;
        int offs;
        int mag;
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            quad = (4 * i) / TAB_SIZE;
            offs = (4 * i) % TAB_SIZE;
            mag  = (quad % 2 == 1) ? quarter_wave(TAB_SIZE - offs) : quarter_wave(offs);
            sine_tab[i] = (quad >= 2) ? -mag : mag;
        end
    end

    // Track configuration, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        dac_result_t want;
        dac_result_t got;
        if (!rst_n)
        begin
            tone_on      = 1'b0;
            freq_x16     = 16'd0;
            vol_pct      = 7'd60;
            carrier_acc  = 32'd0;
            envelope_acc = 32'd0;
            gain_step    = 0;
            fail_tally   = 0;
            dac_queue.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.code = m_axis_tdata[15:0];
                got.done = m_axis_tdata[16];
                if (dac_queue.size() == 0)
                begin
                    fail_tally++;
                    $display("%0t: unexpected output transaction, expected none, actual %0d/%0b",
                             $time, got.code, got.done);
                end
                else
                begin
                    want = dac_queue.pop_front();
                    if (got.code !== want.code)
                    begin
                        fail_tally++;
                        $display("%0t: dac_code mismatch, expected %0d, actual %0d",
                                 $time, want.code, got.code);
                    end
                    if (got.done !== want.done)
                    begin
                        fail_tally++;
                        $display("%0t: fade_finished mismatch, expected %0b, actual %0b",
                                 $time, want.done, got.done);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_dac(amst_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[15:0],
                                s_axis_tdata[16], want))
                    dac_queue.push_back(want);
            end
            if (cfg_we)
            begin
                case (amst_pkg::cfg_reg_t'(cfg_addr))
                    amst_pkg::REG_TONE_ENABLE: tone_on  = cfg_wdata[0];
                    amst_pkg::REG_TARGET_FREQ: freq_x16 = cfg_wdata[15:0];
                    amst_pkg::REG_VOLUME:      vol_pct  = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            pending    <= dac_queue.size();
            fail_count <= fail_tally;
        end
    end

endmodule

>>> sim/tb_am_sine_tone_synth_with_fade.sv
// ----------------------------------------------------------------------------
// tb_am_sine_tone_synth_with_fade
// Drives tone ticks and faded source samples through the synthesiser under
// changing settings and random back-pressure; the checker predicts each code.
// ----------------------------------------------------------------------------
module tb_am_sine_tone_synth_with_fade;
    timeunit 1ns;
    timeprecision 1ps;

    import amst_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 60;
    localparam int RAMP_ITEMS    = 400;
    localparam int RANDOM_PHASES = 9;
    localparam int RAMP_PHASE    = 4;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata     = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      s_axis_tuser  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    logic calm    = 1'b0;
    logic rx_hold = 1'b0;

    am_sine_tone_synth_with_fade DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    amst_tone_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Source sample with a bias towards the extremes
    function automatic logic [15:0] rand_pcm();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one input transaction, hold until accepted, then maybe idle
    task automatic send_item(input cmd_t cmd, input logic [15:0] pcm, input logic up);
        int gap;
        s_axis_tdata  <= {7'd0, up, pcm};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid, drain every expected result, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            if (rx_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int          r;
        int          n_items;
        int          up_bias;
        logic [15:0] freq;
        logic [15:0] vol;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: tone off, so only source samples produce codes
        send_item(CMD_TONE, 16'h0000, 1'b0);
        send_item(CMD_SOURCE, 16'd12345, 1'b0);    // gain already at zero
        send_item(CMD_SOURCE, 16'h8000, 1'b1);
        send_item(CMD_SOURCE, 16'h7FFF, 1'b1);
        send_item(CMD_SOURCE, 16'h0000, 1'b1);
        send_item(CMD_SOURCE, 16'h7FFF, 1'b0);
        send_item(CMD_SOURCE, 16'hFFFF, 1'b0);
        send_item(CMD_SOURCE, 16'h8000, 1'b0);     // fade-out reaches zero

        // Envelope path at its upper frequency limit, full volume
        settle();
        cfg_write(REG_TONE_ENABLE, 16'd1);
        cfg_write(REG_VOLUME, 16'd100);
        cfg_write(REG_TARGET_FREQ, 16'd480);
        repeat (3) send_item(CMD_TONE, 16'h0000, 1'b0);

        // Slowest envelope
        settle();
        cfg_write(REG_TARGET_FREQ, 16'd1);
        repeat (2) send_item(CMD_TONE, 16'hFFFF, 1'b1);

        // Direct tone just above the limit, volume saturating
        settle();
        cfg_write(REG_VOLUME, 16'd127);
        cfg_write(REG_TARGET_FREQ, 16'd481);
        repeat (2) send_item(CMD_TONE, 16'h0000, 1'b0);

        // Clamped frequency at silence
        settle();
        cfg_write(REG_VOLUME, 16'd0);
        cfg_write(REG_TARGET_FREQ, 16'hFFFF);
        repeat (2) send_item(CMD_TONE, 16'h0000, 1'b0);
        send_item(CMD_SOURCE, 16'h7FFF, 1'b1);

        // Clamp boundary
        settle();
        cfg_write(REG_VOLUME, 16'd100);
        cfg_write(REG_TARGET_FREQ, 16'd16000);
        repeat (2) send_item(CMD_TONE, 16'h0000, 1'b0);

        // Tone disabled again: ticks vanish, sources still play
        settle();
        cfg_write(REG_TONE_ENABLE, 16'd0);
        send_item(CMD_TONE, 16'h0000, 1'b0);
        send_item(CMD_SOURCE, 16'h8000, 1'b1);

        // Random phases, each under fresh settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            calm = (p % 4 == 3);
            r = $urandom_range(0, 99);
            if (r < 8)
                freq = 16'd0;
            else if (r < 40)
                freq = 16'($urandom_range(1, AM_LIMIT));
            else if (r < 80)
                freq = 16'($urandom_range(AM_LIMIT + 1, DIRECT_MAX));
            else
                freq = 16'($urandom_range(DIRECT_MAX + 1, 65535));
            r = $urandom_range(0, 9);
            if (r == 0)
                vol = 16'd0;
            else if (r == 1)
                vol = 16'd100;
            else if (r == 2)
                vol = 16'd127;
            else
                vol = 16'($urandom_range(0, 127));
            if (p == RAMP_PHASE)
                vol = 16'd100;
            cfg_write(REG_TONE_ENABLE, 16'($urandom_range(0, 4) != 0));
            cfg_write(REG_VOLUME, vol);
            cfg_write(REG_TARGET_FREQ, freq);
            up_bias = $urandom_range(10, 90);
            n_items = (p == RAMP_PHASE) ? RAMP_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n_items; i++)
            begin
                // Long receiver hold-off while the sender keeps offering
                if (p == 1 && i == 10)
                    rx_hold = 1'b1;
                // Sender pause until the pipeline has drained
                if (p == 2 && i == 50)
                begin
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending != 0);
                end
                if (p == RAMP_PHASE)
                    send_item(CMD_SOURCE, rand_pcm(), 1'b1);    // ramp the gain upward
                else if ($urandom_range(0, 1) == 0)
                    send_item(CMD_TONE, 16'($urandom), 1'($urandom));
                else
                    send_item(CMD_SOURCE, rand_pcm(), $urandom_range(0, 99) < up_bias);
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
sv/amst_pkg.sv
sv/amst_phase_inc.sv
sv/amst_muldiv.sv
sv/am_sine_tone_synth_with_fade.sv
sim/amst_tone_checker.sv
sim/tb_am_sine_tone_synth_with_fade.sv
